// File: hw/rtl/ijp_pkg.sv
`default_nettype none
package ijp_pkg;

    // storage geometry
    localparam int PLANE_DEPTH_DEF = 16384;
    localparam int OFFS_W          = 14;
    localparam int CODE_W          = 16;
    localparam int MAX_RES         = 4;

    // two-byte code space
    localparam int ROW_CELLS = 94;
    localparam int PUA_FIRST = 94 * 94;
    localparam int PUA_END   = 114 * 94;
    localparam logic [CODE_W-1:0] PUA_SHIFT = 16'(32'he000 - PUA_FIRST);

    // control and escape bytes
    localparam logic [7:0] CH_ESC       = 8'h1b;
    localparam logic [7:0] CH_SO        = 8'h0e;
    localparam logic [7:0] CH_SI        = 8'h0f;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_B         = 8'h42;
    localparam logic [7:0] CH_D         = 8'h44;
    localparam logic [7:0] CH_H         = 8'h48;
    localparam logic [7:0] CH_I         = 8'h49;
    localparam logic [7:0] CH_J         = 8'h4a;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_TILDE     = 8'h7e;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DEL       = 8'h7f;
    localparam logic [7:0] KANA7_END    = 8'h60;
    localparam logic [7:0] LEAD_END     = 8'h93;
    localparam logic [7:0] HIGH_FIRST   = 8'h80;
    localparam logic [7:0] KANA8_LOW    = 8'ha0;
    localparam logic [7:0] KANA8_END    = 8'he0;
    localparam logic [7:0] CHAR_FIRST   = 8'h21;

    // fixed output code points
    localparam logic [CODE_W-1:0] U_YEN        = 16'h00a5;
    localparam logic [CODE_W-1:0] U_OVERLINE   = 16'h203e;
    localparam logic [CODE_W-1:0] U_KANA7_BASE = 16'hff40;
    localparam logic [CODE_W-1:0] U_KANA8_BASE = 16'hfec0;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FLUSH = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_UNICODE = 2'd0,
        KIND_JIS0208 = 2'd1,
        KIND_JIS0212 = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        MODE_ASCII   = 3'd0,
        MODE_LATIN   = 3'd1,
        MODE_KANA    = 3'd2,
        MODE_JIS0208 = 3'd3,
        MODE_JIS0212 = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        SUB_IDLE             = 3'd0,
        SUB_TRAIL            = 3'd1,
        SUB_ESC              = 3'd2,
        SUB_ESC_DOLLAR       = 3'd3,
        SUB_ESC_DOLLAR_PAREN = 3'd4,
        SUB_ESC_PAREN        = 3'd5
    } sub_t;

    // results of one request, the last one possibly waiting on a store read
    typedef struct packed {
        logic [2:0]                        n;
        logic [MAX_RES-1:0][CODE_W-1:0]    code;
        kind_t [MAX_RES-1:0]               kind;
        logic                              lk;
        logic                              plane;
        logic                              hit;
        logic [OFFS_W-1:0]                 s;
        logic [CODE_W-1:0]                 pair;
    } bundle_t;

endpackage
`default_nettype wire

// File: hw/rtl/ijp_in_if.sv
`default_nettype none
interface ijp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  in_byte;
    logic [14:0] map_index;
    logic [15:0] map_value;

    modport source (output valid, output req_type, output in_byte, output map_index,
                    output map_value, input ready);
    modport sink (input valid, input req_type, input in_byte, input map_index,
                  input map_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ijp_out_if.sv
`default_nettype none
interface ijp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code;
    logic [1:0]  kind;
    logic        last;

    modport source (output valid, output code, output kind, output last, input ready);
    modport sink (input valid, input code, input kind, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ijp_ram.sv
`default_nettype none
module ijp_ram #(
    parameter int W = 16,
    parameter int D = 1024,
    localparam int AW = $clog2(D)
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [W-1:0]  wdata,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ijp_front.sv
`default_nettype none
module ijp_front #(
    parameter int PLANE_DEPTH = ijp_pkg::PLANE_DEPTH_DEF,
    localparam int AW = $clog2(2 * PLANE_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ijp_in_if.sink                     byte_in,
    input  logic                       s1_ready,
    output ijp_pkg::bundle_t           bnd,
    output logic                       bnd_valid,
    output logic                       ram_we,
    output logic                       ram_re,
    output logic [AW-1:0]              ram_addr,
    output logic [ijp_pkg::CODE_W-1:0] ram_wdata
);

    ijp_pkg::mode_t mode_reg, mode_next;
    ijp_pkg::sub_t  sub_reg, sub_next;
    logic [7:0]     lead_reg, lead_next;

    logic           clr_busy_reg, clr_busy_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;

    logic                        acc;
    logic [7:0]                  c;
    logic                        trail_ok;
    logic [6:0]                  row;
    logic [6:0]                  col;
    logic [ijp_pkg::OFFS_W-1:0]  s;
    logic                        rd_plane;
    logic                        rd_hit;
    logic [AW-1:0]               rd_addr;
    logic [ijp_pkg::OFFS_W-1:0]  wr_offs;
    logic                        wr_hit;
    logic [AW-1:0]               wr_addr;
    logic                        is_write;
    logic                        is_lookup;

    logic [2:0]                  cnt;
    logic [1:0]                  slot;
    logic                        run_idle;
    logic                        e_put;
    logic [ijp_pkg::CODE_W-1:0]  e_code;
    ijp_pkg::kind_t              e_kind;

    assign c   = byte_in.in_byte;
    assign acc = byte_in.valid && byte_in.ready;
    assign byte_in.ready = !clr_busy_reg && s1_ready;

    // two-byte code offset inside its plane
    assign trail_ok = (c > ijp_pkg::CH_SPACE) && (c < ijp_pkg::CH_DEL);
    assign row      = 7'(lead_reg - ijp_pkg::CHAR_FIRST);
    assign col      = 7'(c - ijp_pkg::CHAR_FIRST);
    assign s        = ijp_pkg::OFFS_W'(row) * ijp_pkg::OFFS_W'(ijp_pkg::ROW_CELLS)
                      + ijp_pkg::OFFS_W'(col);
    assign rd_plane = (mode_reg != ijp_pkg::MODE_JIS0208);
    assign rd_hit   = AW'(s) < AW'(PLANE_DEPTH);
    assign rd_addr  = rd_plane ? AW'(PLANE_DEPTH) + AW'(s) : AW'(s);

    assign wr_offs  = byte_in.map_index[ijp_pkg::OFFS_W-1:0];
    assign wr_hit   = AW'(wr_offs) < AW'(PLANE_DEPTH);
    assign wr_addr  = byte_in.map_index[ijp_pkg::OFFS_W] ? AW'(PLANE_DEPTH) + AW'(wr_offs)
                                                          : AW'(wr_offs);

    assign is_write  = (byte_in.req_type == ijp_pkg::REQ_WRITE) && wr_hit;
    assign is_lookup = (byte_in.req_type == ijp_pkg::REQ_BYTE) &&
                       (sub_reg == ijp_pkg::SUB_TRAIL) && trail_ok && rd_hit;

    // store port: clearing pass first, then writes and lookups
    assign ram_we    = clr_busy_reg || (acc && is_write);
    assign ram_re    = acc && is_lookup;
    assign ram_addr  = clr_busy_reg ? clr_cnt_reg : (is_write ? wr_addr : rd_addr);
    assign ram_wdata = clr_busy_reg ? '0 : byte_in.map_value;

    assign bnd_valid = acc;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg + AW'(1);
        clr_busy_next = clr_busy_reg && (clr_cnt_reg != AW'(2 * PLANE_DEPTH - 1));
    end

    // decode of one request against the current mode and substate
    always_comb
    begin
        mode_next = mode_reg;
        sub_next  = sub_reg;
        lead_next = lead_reg;
        bnd       = '0;
        cnt       = 3'd0;
        run_idle  = 1'b0;
        e_put     = 1'b0;
        e_code    = '0;
        e_kind    = ijp_pkg::KIND_UNICODE;
        slot      = 2'd0;

        bnd.s     = s;
        bnd.plane = rd_plane;
        bnd.hit   = rd_hit;
        bnd.pair  = {lead_reg, c};

        case (byte_in.req_type)
            ijp_pkg::REQ_BYTE:
            begin
                case (sub_reg)
                    ijp_pkg::SUB_IDLE:
                    begin
                        run_idle = 1'b1;
                    end
                    ijp_pkg::SUB_TRAIL:
                    begin
                        sub_next     = ijp_pkg::SUB_IDLE;
                        bnd.code[0]  = {lead_reg, c};
                        bnd.kind[0]  = ijp_pkg::KIND_INVALID;
                        bnd.lk       = trail_ok;
                        cnt          = 3'd1;
                    end
                    ijp_pkg::SUB_ESC:
                    begin
                        if (c == ijp_pkg::CH_DOLLAR)
                        begin
                            sub_next = ijp_pkg::SUB_ESC_DOLLAR;
                        end
                        else if (c == ijp_pkg::CH_LPAREN)
                        begin
                            sub_next = ijp_pkg::SUB_ESC_PAREN;
                        end
                        else
                        begin
                            sub_next    = ijp_pkg::SUB_IDLE;
                            bnd.code[0] = 16'(ijp_pkg::CH_ESC);
                            bnd.kind[0] = ijp_pkg::KIND_INVALID;
                            cnt         = 3'd1;
                            run_idle    = 1'b1;
                        end
                    end
                    ijp_pkg::SUB_ESC_DOLLAR:
                    begin
                        if (c == ijp_pkg::CH_AT || c == ijp_pkg::CH_B)
                        begin
                            mode_next = ijp_pkg::MODE_JIS0208;
                            sub_next  = ijp_pkg::SUB_IDLE;
                        end
                        else if (c == ijp_pkg::CH_LPAREN)
                        begin
                            sub_next = ijp_pkg::SUB_ESC_DOLLAR_PAREN;
                        end
                        else
                        begin
                            sub_next    = ijp_pkg::SUB_IDLE;
                            bnd.code[0] = 16'(ijp_pkg::CH_ESC);
                            bnd.kind[0] = ijp_pkg::KIND_INVALID;
                            bnd.code[1] = 16'(ijp_pkg::CH_DOLLAR);
                            cnt         = 3'd2;
                            run_idle    = 1'b1;
                        end
                    end
                    ijp_pkg::SUB_ESC_DOLLAR_PAREN:
                    begin
                        if (c == ijp_pkg::CH_AT || c == ijp_pkg::CH_B)
                        begin
                            mode_next = ijp_pkg::MODE_JIS0208;
                            sub_next  = ijp_pkg::SUB_IDLE;
                        end
                        else if (c == ijp_pkg::CH_D)
                        begin
                            mode_next = ijp_pkg::MODE_JIS0212;
                            sub_next  = ijp_pkg::SUB_IDLE;
                        end
                        else
                        begin
                            sub_next    = ijp_pkg::SUB_IDLE;
                            bnd.code[0] = 16'(ijp_pkg::CH_ESC);
                            bnd.kind[0] = ijp_pkg::KIND_INVALID;
                            bnd.code[1] = 16'(ijp_pkg::CH_DOLLAR);
                            bnd.code[2] = 16'(ijp_pkg::CH_LPAREN);
                            cnt         = 3'd3;
                            run_idle    = 1'b1;
                        end
                    end
                    ijp_pkg::SUB_ESC_PAREN:
                    begin
                        if (c == ijp_pkg::CH_B || c == ijp_pkg::CH_H)
                        begin
                            mode_next = ijp_pkg::MODE_ASCII;
                            sub_next  = ijp_pkg::SUB_IDLE;
                        end
                        else if (c == ijp_pkg::CH_J)
                        begin
                            mode_next = ijp_pkg::MODE_LATIN;
                            sub_next  = ijp_pkg::SUB_IDLE;
                        end
                        else if (c == ijp_pkg::CH_I)
                        begin
                            mode_next = ijp_pkg::MODE_KANA;
                            sub_next  = ijp_pkg::SUB_IDLE;
                        end
                        else
                        begin
                            sub_next    = ijp_pkg::SUB_IDLE;
                            bnd.code[0] = 16'(ijp_pkg::CH_ESC);
                            bnd.kind[0] = ijp_pkg::KIND_INVALID;
                            bnd.code[1] = 16'(ijp_pkg::CH_LPAREN);
                            cnt         = 3'd2;
                            run_idle    = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = ijp_pkg::MODE_ASCII;
                        sub_next  = ijp_pkg::SUB_IDLE;
                    end
                endcase
            end
            ijp_pkg::REQ_FLUSH:
            begin
                if (sub_reg == ijp_pkg::SUB_TRAIL)
                begin
                    sub_next    = ijp_pkg::SUB_IDLE;
                    bnd.code[0] = 16'(lead_reg);
                    bnd.kind[0] = ijp_pkg::KIND_INVALID;
                    cnt         = 3'd1;
                end
            end
            default:
            begin
            end
        endcase

        // single byte in idle substate, also after a failed escape
        if (run_idle)
        begin
            if (c == ijp_pkg::CH_ESC)
            begin
                sub_next = ijp_pkg::SUB_ESC;
            end
            else if (c == ijp_pkg::CH_SO)
            begin
                mode_next = ijp_pkg::MODE_KANA;
            end
            else if (c == ijp_pkg::CH_SI)
            begin
                mode_next = ijp_pkg::MODE_ASCII;
            end
            else if (mode_reg == ijp_pkg::MODE_LATIN && c == ijp_pkg::CH_BACKSLASH)
            begin
                e_put  = 1'b1;
                e_code = ijp_pkg::U_YEN;
            end
            else if (mode_reg == ijp_pkg::MODE_LATIN && c == ijp_pkg::CH_TILDE)
            begin
                e_put  = 1'b1;
                e_code = ijp_pkg::U_OVERLINE;
            end
            else if (mode_reg == ijp_pkg::MODE_KANA && c > ijp_pkg::CH_SPACE &&
                     c < ijp_pkg::KANA7_END)
            begin
                e_put  = 1'b1;
                e_code = ijp_pkg::U_KANA7_BASE + 16'(c);
            end
            else if ((mode_reg == ijp_pkg::MODE_JIS0208 || mode_reg == ijp_pkg::MODE_JIS0212)
                     && c > ijp_pkg::CH_SPACE && c < ijp_pkg::LEAD_END)
            begin
                lead_next = c;
                sub_next  = ijp_pkg::SUB_TRAIL;
            end
            else if (c < ijp_pkg::HIGH_FIRST)
            begin
                e_put  = 1'b1;
                e_code = 16'(c);
            end
            else if (c > ijp_pkg::KANA8_LOW && c < ijp_pkg::KANA8_END)
            begin
                e_put  = 1'b1;
                e_code = ijp_pkg::U_KANA8_BASE + 16'(c);
            end
            else
            begin
                e_put  = 1'b1;
                e_code = 16'(c);
                e_kind = ijp_pkg::KIND_INVALID;
            end
        end

        if (e_put)
        begin
            slot           = cnt[1:0];
            bnd.code[slot] = e_code;
            bnd.kind[slot] = e_kind;
            cnt            = cnt + 3'd1;
        end
        bnd.n = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ijp_pkg::MODE_ASCII;
            sub_reg  <= ijp_pkg::SUB_IDLE;
            lead_reg <= '0;
        end
        else if (acc)
        begin
            mode_reg <= mode_next;
            sub_reg  <= sub_next;
            lead_reg <= lead_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store read and write in the same cycle");

    a_trail_done: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> sub_reg == ijp_pkg::SUB_IDLE)
        else $error("lookup did not end the two-byte code");

    a_clear_owns_port: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> ram_we && !byte_in.ready && ram_wdata == '0)
        else $error("clearing pass lost the store port");

endmodule
`default_nettype wire

// File: hw/rtl/ijp_emit.sv
`default_nettype none
module ijp_emit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ijp_pkg::bundle_t           bnd,
    input  logic                       bnd_valid,
    output logic                       s1_ready,
    input  logic [ijp_pkg::CODE_W-1:0] rdata,
    ijp_out_if.source                  result
);

    logic                s1_valid_reg, s1_valid_next;
    ijp_pkg::bundle_t    s1_reg;

    logic                em_valid_reg, em_valid_next;
    logic [1:0]          em_idx_reg, em_idx_next;
    logic [2:0]          em_cnt_reg, em_cnt_next;
    logic [ijp_pkg::MAX_RES-1:0][ijp_pkg::CODE_W-1:0] em_code_reg;
    ijp_pkg::kind_t [ijp_pkg::MAX_RES-1:0]             em_kind_reg;

    logic                        em_is_last;
    logic                        em_done;
    logic                        s1_move;
    logic                        em_load;
    logic [ijp_pkg::CODE_W-1:0]  w;
    logic [1:0]                  lk_slot;
    logic [ijp_pkg::MAX_RES-1:0][ijp_pkg::CODE_W-1:0] res_code;
    ijp_pkg::kind_t [ijp_pkg::MAX_RES-1:0]             res_kind;

    assign em_is_last = ({1'b0, em_idx_reg} == em_cnt_reg - 3'd1);
    assign em_done    = em_valid_reg && result.ready && em_is_last;
    assign s1_move    = s1_valid_reg && (s1_reg.n == 3'd0 || !em_valid_reg || em_done);
    assign s1_ready   = !s1_valid_reg || s1_move;
    assign em_load    = s1_move && (s1_reg.n != 3'd0);

    // finish the store lookup, with private-use fallback for upper 0208 rows
    always_comb
    begin
        w        = s1_reg.hit ? rdata : '0;
        res_code = s1_reg.code;
        res_kind = s1_reg.kind;
        lk_slot  = 2'(s1_reg.n - 3'd1);
        if (w == '0 && !s1_reg.plane &&
            s1_reg.s >= ijp_pkg::OFFS_W'(ijp_pkg::PUA_FIRST) &&
            s1_reg.s < ijp_pkg::OFFS_W'(ijp_pkg::PUA_END))
        begin
            w = ijp_pkg::CODE_W'(s1_reg.s) + ijp_pkg::PUA_SHIFT;
        end
        if (s1_reg.lk)
        begin
            if (w != '0)
            begin
                res_code[lk_slot] = w;
                res_kind[lk_slot] = ijp_pkg::KIND_UNICODE;
            end
            else
            begin
                res_code[lk_slot] = s1_reg.pair;
                res_kind[lk_slot] = s1_reg.plane ? ijp_pkg::KIND_JIS0212
                                                 : ijp_pkg::KIND_JIS0208;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_ready ? bnd_valid : s1_valid_reg;
        em_valid_next = em_valid_reg;
        em_idx_next   = em_idx_reg;
        em_cnt_next   = em_cnt_reg;
        if (em_load)
        begin
            em_valid_next = 1'b1;
            em_idx_next   = 2'd0;
            em_cnt_next   = s1_reg.n;
        end
        else if (em_done)
        begin
            em_valid_next = 1'b0;
        end
        else if (em_valid_reg && result.ready)
        begin
            em_idx_next = em_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            em_valid_reg <= 1'b0;
            em_idx_reg   <= '0;
            em_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            em_valid_reg <= em_valid_next;
            em_idx_reg   <= em_idx_next;
            em_cnt_reg   <= em_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && bnd_valid)
        begin
            s1_reg <= bnd;
        end
        if (em_load)
        begin
            em_code_reg <= res_code;
            em_kind_reg <= res_kind;
        end
    end

    assign result.valid = em_valid_reg;
    assign result.code  = em_code_reg[em_idx_reg];
    assign result.kind  = em_kind_reg[em_idx_reg];
    assign result.last  = em_is_last;

    a_em_count: assert property (@(posedge clk) disable iff (!rst_n)
        em_valid_reg |-> em_cnt_reg != 3'd0 && {1'b0, em_idx_reg} < em_cnt_reg)
        else $error("result index outside the loaded group");

    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> rdata === $past(rdata))
        else $error("store read data changed under a stalled lookup");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        em_valid_reg && !result.ready |=>
            em_valid_reg && $stable(em_idx_reg) && $stable(em_cnt_reg))
        else $error("waiting result moved before it was taken");

endmodule
`default_nettype wire

// File: hw/rtl/iso2022jp_byte_decoder_core.sv
`default_nettype none
// channel   dir  payload                                   request meaning
// byte_in   in   req_type, in_byte, map_index, map_value   stream byte, store write, flush
// result    out  code, kind, last                          one decoded result
//
// a request is taken when valid and ready are both high: mode and escape substate update
// as it is taken, so the next request can follow at once while byte_in.ready stays high
// a two-byte code reads the mapping store (one read port, registered read data);
// like every result it passes the lookup register and the result register, in that order,
// before it is offered; each result holds the output until result.ready takes it, and a
// request gives n results, or none (up to four after a failed escape)
// after reset a clearing pass writes zero to all 2*PLANE_DEPTH store entries,
// one per cycle (32768 entries by default); byte_in.ready stays low meanwhile
// a stalled result stalls the lookup stage, which then holds byte_in.ready low
module iso2022jp_byte_decoder_core #(
    parameter int PLANE_DEPTH = ijp_pkg::PLANE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ijp_in_if.sink     byte_in,
    ijp_out_if.source  result
);

    // plane 0 holds 0208 codes, plane 1 holds 0212 codes
    localparam int DEPTH = 2 * PLANE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    ijp_pkg::bundle_t            bnd;
    logic                        bnd_valid;
    logic                        s1_ready;
    logic                        ram_we;
    logic                        ram_re;
    logic [AW-1:0]               ram_addr;
    logic [ijp_pkg::CODE_W-1:0]  ram_wdata;
    logic [ijp_pkg::CODE_W-1:0]  ram_rdata;

    // decode, mode state and store port control
    ijp_front #(
        .PLANE_DEPTH (PLANE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .s1_ready  (s1_ready),
        .bnd       (bnd),
        .bnd_valid (bnd_valid),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata)
    );

    // mapping store
    ijp_ram #(
        .W (ijp_pkg::CODE_W),
        .D (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // lookup resolve and result sequencing
    ijp_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .bnd       (bnd),
        .bnd_valid (bnd_valid),
        .s1_ready  (s1_ready),
        .rdata     (ram_rdata),
        .result    (result)
    );

endmodule
`default_nettype wire
